### hw/rtl/rbd_pkg.sv
// rbd_pkg: types and codes shared by the ring buffer deque modules
// no dependencies
`default_nettype none

package rbd_pkg;

   localparam logic [1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [1:0] CMD_POP     = 2'd2;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   localparam int unsigned CAP_W = 8;
   localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] data_out;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic exec;
   } ctrl_cmd_type;

endpackage

`default_nettype wire

### hw/rtl/rbd_ctrl.sv
// rbd_ctrl: sequencer for the ring buffer deque, one item at a time
// depends on rbd_pkg
`default_nettype none

module rbd_ctrl
   import rbd_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output ctrl_cmd_type cmd,
   input  wire logic   rsp_stall,
   output logic        req_stall,
   output logic        rsp_valid
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RESP
   } state_type;

   state_type state_ff;
   logic      req_stall_ff;
   logic      rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_stall_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff     <= S_EXEC;
                  req_stall_ff <= 1'b1;
               end
            end
            S_EXEC: begin
               state_ff     <= S_RESP;
               rsp_valid_ff <= 1'b1;
            end
            S_RESP: begin
               if (!rsp_stall) begin
                  state_ff     <= S_IDLE;
                  rsp_valid_ff <= 1'b0;
                  req_stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               req_stall_ff <= 1'b0;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;
   assign cmd.load  = req_valid && !req_stall_ff;
   assign cmd.exec  = (state_ff == S_EXEC);

endmodule

`default_nettype wire

### hw/rtl/rbd_datapath.sv
// rbd_datapath: slot memory, head and tail indices, capacity register, result register
// depends on rbd_pkg
`default_nettype none

module rbd_datapath
   import rbd_pkg::*;
#(
   parameter int unsigned DEPTH = 128
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ctrl_cmd_type     cmd,
   input  wire req_type          req_payload,
   input  wire logic             csr_write_en,
   input  wire logic [CAP_W-1:0] csr_write_data,
   output rsp_type               rsp_payload
);

   localparam int unsigned IW = $clog2(DEPTH);
   localparam int unsigned CW = (IW + 1 > CAP_W) ? IW + 1 : CAP_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   logic signed [31:0] mem [DEPTH];

   logic [CAP_W-1:0]   cap_ff;
   logic [IW-1:0]      head_ff, head_in;
   logic [IW-1:0]      tail_ff, tail_in;
   logic               empty_ff, empty_in;
   logic [1:0]         cmd_ff;
   logic signed [31:0] value_ff;
   logic signed [31:0] rd_data_ff;
   rsp_type            rsp_ff, rsp_in;

   logic [CW-1:0]      cap_raw;
   logic [CW-1:0]      cap_eff;
   logic [CW-1:0]      tail_next;
   logic [CW-1:0]      head_next;
   logic [CW-1:0]      cap_less_one;
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   logic [IW-1:0]      rd_addr;

   // capacity in force, clamped to 1..DEPTH
   always_comb begin
      cap_raw = CW'(cap_ff);
      if (cap_raw == '0) begin
         cap_eff = ONE_C;
      end else if (cap_raw > DEPTH_C) begin
         cap_eff = DEPTH_C;
      end else begin
         cap_eff = cap_raw;
      end
      cap_less_one = cap_eff - ONE_C;
      tail_next    = ((CW'(tail_ff) + ONE_C) >= cap_eff) ? '0 : CW'(tail_ff) + ONE_C;
      head_next    = ((CW'(head_ff) + ONE_C) >= cap_eff) ? '0 : CW'(head_ff) + ONE_C;
   end

   assign rd_addr = (req_payload.command == CMD_DEQUEUE) ? head_ff : tail_ff;

   always_comb begin
      head_in         = head_ff;
      tail_in         = tail_ff;
      empty_in        = empty_ff;
      wr_en           = 1'b0;
      wr_addr         = tail_ff;
      rsp_in.data_out = '0;
      rsp_in.status   = ST_DONE;
      case (cmd_ff)
         CMD_ENQUEUE: begin
            if (empty_ff) begin
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b0;
               wr_en    = 1'b1;
               wr_addr  = '0;
            end else if (tail_next == CW'(head_ff)) begin
               rsp_in.status = ST_FULL;
            end else begin
               tail_in = tail_next[IW-1:0];
               wr_en   = 1'b1;
               wr_addr = tail_next[IW-1:0];
            end
         end
         CMD_DEQUEUE, CMD_POP: begin
            if (empty_ff) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               rsp_in.data_out = rd_data_ff;
               if (head_ff == tail_ff) begin
                  head_in  = '0;
                  tail_in  = '0;
                  empty_in = 1'b1;
               end else if (cmd_ff == CMD_DEQUEUE) begin
                  head_in = head_next[IW-1:0];
               end else if (tail_ff == '0) begin
                  tail_in = cap_less_one[IW-1:0];
               end else begin
                  tail_in = tail_ff - IW'(1);
               end
            end
         end
         default: begin
            rsp_in.status = ST_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
      end else begin
         if (csr_write_en) begin
            cap_ff <= csr_write_data;
         end
         if (cmd.exec) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            empty_ff <= empty_in;
         end
      end
   end

   // item and result registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff   <= req_payload.command;
         value_ff <= req_payload.value;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         mem[wr_addr] <= value_ff;
      end
      if (cmd.load) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

### hw/rtl/ring_buffer_deque.sv
// ring_buffer_deque: circular buffer of signed words usable as queue or stack
// Items on the req_ channel carry a command (enqueue at tail, dequeue from
// head, pop from tail) and a value. Each item gives exactly one result on
// the rsp_ channel: the removed word, or zero, and a status (done, full so
// the enqueue was dropped, empty so nothing was removed).
// An item is taken when req_valid is high and req_stall low; a result is
// taken when rsp_valid is high and rsp_stall low.
// After an item is taken the block passes through its execute state, then
// raises rsp_valid together with the registered result.
// No new item is taken until the last result is taken; the slot
// memory is read with a registered port in the accept cycle and written in
// the following one, with one item in the block at a time.
// While the receiver stalls, the result holds and req_stall stays high.
// csr_write_en writes the capacity (clamped to 1..DEPTH); write it only
// while the block is idle and the buffer empty.
// Reset empties the buffer, sets the capacity to 128 and leaves slot
// contents undefined; there is no clearing pass.
// depends on rbd_pkg, rbd_ctrl, rbd_datapath
`default_nettype none

module ring_buffer_deque
   import rbd_pkg::*;
#(
   parameter int unsigned DEPTH = 128
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_payload,
   input  wire logic             csr_write_en,
   input  wire logic [CAP_W-1:0] csr_write_data
);

   ctrl_cmd_type cmd;

   rbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .cmd       (cmd),
      .rsp_stall (rsp_stall),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid)
   );

   rbd_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_payload    (req_payload),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rsp_payload    (rsp_payload)
   );

endmodule

`default_nettype wire

### test/ring_buffer_deque_tb.sv
`timescale 1ns / 100ps
// ring_buffer_deque_tb: self-checking testbench for the ring buffer deque
// a directed table with pinned results, then random phases at several capacities,
// the rest by a built-in deque predictor; depends on rbd_pkg and ring_buffer_deque

module ring_buffer_deque_tb
   import rbd_pkg::*;
;

   localparam int unsigned BUF_DEPTH = 128;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int unsigned N_PLAN = 25;
   localparam int unsigned N_PHASES = 8;

   typedef struct packed {
      logic               csr;
      logic [CAP_W-1:0]   cap;
      logic [1:0]         cmd;
      logic signed [31:0] val;
      logic               pinned;
      logic signed [31:0] want_data;
      logic [1:0]         want_status;
   } plan_row_type;

   typedef struct packed {
      logic    on;
      rsp_type want;
   } pinned_result_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_payload;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_type          rsp_payload;
   logic             csr_write_en;
   logic [CAP_W-1:0] csr_write_data;

   // predictor state
   logic signed [31:0] mem_words [BUF_DEPTH];
   int unsigned        head_ptr;
   int unsigned        tail_ptr;
   bit                 buf_empty;
   logic [CAP_W-1:0]   cap_reg;

   rsp_type           pending_results [$];
   pinned_result_type pinned_q [$];
   int unsigned       fail_count = 0;
   int unsigned       n_items = 0;
   int unsigned       n_results = 0;
   int unsigned       n_full = 0;
   int unsigned       n_empty = 0;
   int unsigned       burst_left = 0;
   bit                hold_wanted = 1'b0;

   plan_row_type directed_plan [N_PLAN] = '{
      '{1'b0, 8'd0,   CMD_POP,     32'h0,        1'b1, 32'h0,        ST_EMPTY},
      '{1'b0, 8'd0,   CMD_DEQUEUE, 32'h0,        1'b1, 32'h0,        ST_EMPTY},
      '{1'b0, 8'd0,   CMD_UNUSED,  32'h7FFFFFFF, 1'b1, 32'h0,        ST_DONE},
      '{1'b0, 8'd0,   CMD_ENQUEUE, 32'h7FFFFFFF, 1'b1, 32'h0,        ST_DONE},
      '{1'b0, 8'd0,   CMD_ENQUEUE, 32'h80000000, 1'b1, 32'h0,        ST_DONE},
      '{1'b0, 8'd0,   CMD_ENQUEUE, 32'hFFFFFFFF, 1'b1, 32'h0,        ST_DONE},
      '{1'b0, 8'd0,   CMD_DEQUEUE, 32'h0,        1'b1, 32'h7FFFFFFF, ST_DONE},
      '{1'b0, 8'd0,   CMD_POP,     32'h0,        1'b1, 32'hFFFFFFFF, ST_DONE},
      '{1'b0, 8'd0,   CMD_POP,     32'h0,        1'b1, 32'h80000000, ST_DONE},
      '{1'b0, 8'd0,   CMD_DEQUEUE, 32'h0,        1'b1, 32'h0,        ST_EMPTY},
      '{1'b1, 8'd2,   CMD_ENQUEUE, 32'h0,        1'b0, 32'h0,        ST_DONE},
      '{1'b0, 8'd0,   CMD_ENQUEUE, 32'd5,        1'b1, 32'h0,        ST_DONE},
      '{1'b0, 8'd0,   CMD_ENQUEUE, 32'd6,        1'b1, 32'h0,        ST_DONE},
      '{1'b0, 8'd0,   CMD_ENQUEUE, 32'd7,        1'b1, 32'h0,        ST_FULL},
      '{1'b0, 8'd0,   CMD_UNUSED,  32'hFFFFFFFF, 1'b1, 32'h0,        ST_DONE},
      '{1'b0, 8'd0,   CMD_DEQUEUE, 32'h0,        1'b1, 32'd5,        ST_DONE},
      '{1'b0, 8'd0,   CMD_ENQUEUE, 32'd8,        1'b0, 32'h0,        ST_DONE},
      '{1'b0, 8'd0,   CMD_POP,     32'h0,        1'b0, 32'h0,        ST_DONE},
      '{1'b0, 8'd0,   CMD_POP,     32'h0,        1'b0, 32'h0,        ST_DONE},
      '{1'b0, 8'd0,   CMD_POP,     32'h0,        1'b1, 32'h0,        ST_EMPTY},
      '{1'b1, 8'd0,   CMD_ENQUEUE, 32'h0,        1'b0, 32'h0,        ST_DONE},
      '{1'b0, 8'd0,   CMD_ENQUEUE, 32'h12345678, 1'b1, 32'h0,        ST_DONE},
      '{1'b0, 8'd0,   CMD_ENQUEUE, 32'h0,        1'b1, 32'h0,        ST_FULL},
      '{1'b0, 8'd0,   CMD_DEQUEUE, 32'h0,        1'b0, 32'h0,        ST_DONE},
      '{1'b0, 8'd0,   CMD_DEQUEUE, 32'h0,        1'b1, 32'h0,        ST_EMPTY}
   };

   ring_buffer_deque #(
      .DEPTH(BUF_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #400000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic int unsigned slots_in_use(input logic [CAP_W-1:0] c);
      if (c == 0) return 1;
      if (c > BUF_DEPTH) return BUF_DEPTH;
      return 32'(c);
   endfunction

   function automatic rsp_type deque_step(input req_type it);
      rsp_type     r;
      int unsigned cap;
      int unsigned nxt;
      r.data_out = '0;
      r.status = ST_DONE;
      cap = slots_in_use(cap_reg);
      case (it.command)
         CMD_ENQUEUE: begin
            if (buf_empty) begin
               head_ptr = 0;
               tail_ptr = 0;
               mem_words[0] = it.value;
               buf_empty = 1'b0;
            end else begin
               nxt = (tail_ptr + 1 >= cap) ? 0 : tail_ptr + 1;
               if (nxt == head_ptr) begin
                  r.status = ST_FULL;
               end else begin
                  tail_ptr = nxt;
                  mem_words[tail_ptr % BUF_DEPTH] = it.value;
               end
            end
         end
         CMD_DEQUEUE, CMD_POP: begin
            if (buf_empty) begin
               r.status = ST_EMPTY;
            end else if (it.command == CMD_DEQUEUE) begin
               r.data_out = mem_words[head_ptr % BUF_DEPTH];
               if (head_ptr == tail_ptr) begin
                  head_ptr = 0;
                  tail_ptr = 0;
                  buf_empty = 1'b1;
               end else begin
                  head_ptr = (head_ptr + 1 >= cap) ? 0 : head_ptr + 1;
               end
            end else begin
               r.data_out = mem_words[tail_ptr % BUF_DEPTH];
               if (head_ptr == tail_ptr) begin
                  head_ptr = 0;
                  tail_ptr = 0;
                  buf_empty = 1'b1;
               end else if (tail_ptr == 0) begin
                  tail_ptr = cap - 1;
               end else begin
                  tail_ptr = tail_ptr - 1;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // predict on accepted items, check accepted results
   always @(posedge clock) begin
      rsp_type           got;
      pinned_result_type pin;
      if (reset === 1'b1) begin
         head_ptr = 0;
         tail_ptr = 0;
         buf_empty = 1'b1;
         cap_reg = CAP_RESET;
      end else begin
         if (csr_write_en === 1'b1) cap_reg = csr_write_data;
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            n_items++;
            got = deque_step(req_payload);
            pin = (pinned_q.size() != 0) ? pinned_q.pop_front() : '0;
            if (pin.on) got = pin.want;
            if (got.status == ST_FULL) n_full++;
            if (got.status == ST_EMPTY) n_empty++;
            pending_results.push_back(got);
         end
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            n_results++;
            if (pending_results.size() == 0) begin
               $error("result with no item waiting: data_out %0d status %0d",
                      rsp_payload.data_out, rsp_payload.status);
               fail_count++;
            end else begin
               got = pending_results.pop_front();
               if (rsp_payload.data_out !== got.data_out) begin
                  $error("data_out: expected %0d, got %0d", got.data_out,
                         rsp_payload.data_out);
                  fail_count++;
               end
               if (rsp_payload.status !== got.status) begin
                  $error("status: expected %0d, got %0d", got.status,
                         rsp_payload.status);
                  fail_count++;
               end
            end
         end
      end
   end

   // receiver stall pattern, with occasional long hold-offs
   initial begin
      int unsigned seg_len;
      int unsigned style;
      int unsigned k;
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         seg_len = $urandom_range(20, 150);
         style = hold_wanted ? 4 : $urandom_range(0, 6);
         if (style == 4) begin
            hold_wanted = 1'b0;
            rsp_stall <= 1'b1;
            repeat ($urandom_range(150, 400)) @(posedge clock);
         end else begin
            for (k = 0; k < seg_len; k++) begin
               case (style)
                  2: rsp_stall <= ($urandom_range(0, 9) < 3);
                  3: rsp_stall <= ($urandom_range(0, 9) < 7);
                  5: rsp_stall <= k[0];
                  default: rsp_stall <= 1'b0;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   function automatic logic signed [31:0] random_word();
      case ($urandom_range(0, 7))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'h0;
         3: return 32'hFFFFFFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic issue(input logic [1:0] cmd, input logic signed [31:0] val,
                        input logic pinned, input rsp_type want);
      int unsigned       gap;
      req_type           it;
      pinned_result_type pin;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      pin.on = pinned;
      pin.want = want;
      pinned_q.push_back(pin);
      it.command = cmd;
      it.value = val;
      req_valid <= 1'b1;
      req_payload <= it;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   task automatic settle();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   // empty the buffer, with one extra removal that meets an empty buffer
   task automatic drain();
      int unsigned cap;
      int unsigned n;
      int unsigned k;
      settle();
      cap = slots_in_use(cap_reg);
      n = buf_empty ? 0 : ((tail_ptr + cap - head_ptr) % cap) + 1;
      for (k = 0; k <= n; k++)
         issue($urandom_range(0, 1) ? CMD_DEQUEUE : CMD_POP, random_word(), 1'b0, '0);
      settle();
   endtask

   task automatic retune(input logic [CAP_W-1:0] c);
      drain();
      csr_write_en <= 1'b1;
      csr_write_data <= c;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      plan_row_type     row;
      rsp_type          want;
      logic [CAP_W-1:0] caps [N_PHASES];
      int unsigned      mixes [N_PHASES];
      int unsigned      i;
      int unsigned      p;
      int unsigned      k;
      int unsigned      seg_left;
      int unsigned      enq_pct;
      int unsigned      roll;
      logic [1:0]       cmd;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      caps = '{8'd255, 8'd1, 8'd0, 8'd3, 8'd128, 8'd129, 8'd2, 8'd0};
      mixes = '{30, 25, 25, 35, 25, 20, 35, 25};
      caps[6] = CAP_W'($urandom_range(2, 16));
      caps[7] = CAP_W'($urandom_range(0, 255));
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < N_PLAN; i++) begin
         row = directed_plan[i];
         if (row.csr) begin
            retune(row.cap);
         end else begin
            want.data_out = row.want_data;
            want.status = row.want_status;
            issue(row.cmd, row.val, row.pinned, want);
         end
      end

      for (p = 0; p < N_PHASES; p++) begin
         retune(caps[p]);
         if (p == 0 || p == 4) hold_wanted = 1'b1;
         // run up to full and past it
         for (k = 0; k < slots_in_use(caps[p]) + 2; k++)
            issue(CMD_ENQUEUE, random_word(), 1'b0, '0);
         seg_left = 0;
         enq_pct = 50;
         for (k = 0; k < mixes[p]; k++) begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(5, 50);
               case ($urandom_range(0, 2))
                  0: enq_pct = 85;
                  1: enq_pct = 50;
                  default: enq_pct = 15;
               endcase
            end
            seg_left--;
            roll = $urandom_range(0, 99);
            if (roll < 3) cmd = CMD_UNUSED;
            else if (roll < 3 + enq_pct) cmd = CMD_ENQUEUE;
            else cmd = $urandom_range(0, 1) ? CMD_DEQUEUE : CMD_POP;
            issue(cmd, random_word(), 1'b0, '0);
         end
      end
      drain();

      if (pending_results.size() != 0) begin
         $error("%0d results never arrived", pending_results.size());
         fail_count++;
      end
      $display("covered %0d items and %0d results over %0d capacity settings",
               n_items, n_results, N_PHASES + 2);
      $display("full drops expected: %0d, removals from empty expected: %0d",
               n_full, n_empty);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
